[rtl/kto_pkg.sv]
// ============================================================================
// kto_pkg: shared types and constants for the keyed table
// Operation and status codes, the entry record and the controller-datapath
// command and status structs.
// ============================================================================
package kto_pkg;

    localparam int KEY_W   = 64;
    localparam int TTL_W   = 8;
    localparam int CHK_W   = 32;
    localparam int TAG_W   = 64;
    localparam int TIME_W  = 40;
    localparam int TALLY_W = 11;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIND  = 2'd1,
        OP_PRUNE = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_EVICTED  = 3'd2,
        ST_REJECTED = 3'd3,
        ST_FOUND    = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_PRUNED   = 3'd6,
        ST_COUNT    = 3'd7
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key3;
        logic [KEY_W-1:0]  key2;
        logic [KEY_W-1:0]  key1;
        logic [KEY_W-1:0]  key0;
        logic [TTL_W-1:0]  ttl;
        logic [CHK_W-1:0]  chunks;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input item, clear scan state
        logic rd;        // issue a memory read at the scan index
        logic eval;      // evaluate the registered read data
        logic wr_item;   // write the captured item at the target slot
        logic rd_last;   // read the last occupied entry
        logic move_last; // write the read-back last entry at the scan index
        logic set_out;   // build the result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic rejected;
        logic scan_end;  // scan index has reached the bound
        logic hit;       // evaluated entry matched (key, or prune age)
        logic full;
    } sts_t;

endpackage

[rtl/kto_datapath.sv]
// ============================================================================
// kto_datapath: entry memory, scan counter and result registers
// One entry memory read per scan step; the read data is registered and
// compared in the following cycle.
// ============================================================================
module kto_datapath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES),
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kto_pkg::cmd_t                 cmd,
    output kto_pkg::sts_t                 sts,
    input  kto_pkg::entry_t               item_in,
    input  logic [1:0]                    op_in,
    input  logic [kto_pkg::TIME_W-1:0]    max_age,
    output logic [2:0]                    status_out,
    output kto_pkg::entry_t               found_out,
    output logic [kto_pkg::TALLY_W-1:0]   tally_out
);

    kto_pkg::entry_t              mem [TABLE_ENTRIES];
    kto_pkg::entry_t              item_reg;
    logic [1:0]                   op_reg;
    kto_pkg::entry_t              rdata_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             occ_reg;
    logic [CNT_W-1:0]             removed_reg;
    logic [IDX_W-1:0]             oldest_reg;
    logic [kto_pkg::TIME_W-1:0]   oldest_time_reg;
    logic                         upd_reg;
    logic                         evict_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             wr_addr;
    logic                         key_eq;
    logic                         old_hit;
    logic [kto_pkg::TIME_W:0]     age_sum;
    logic                         full;
    logic [CNT_W-1:0]             last_idx;

    assign full     = (occ_reg == CNT_W'(TABLE_ENTRIES));
    assign last_idx = occ_reg - CNT_W'(1);
    assign rd_addr  = cmd.rd_last ? last_idx[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    assign key_eq = (rdata_reg.key0 == item_reg.key0) && (rdata_reg.key1 == item_reg.key1)
                 && (rdata_reg.key2 == item_reg.key2) && (rdata_reg.key3 == item_reg.key3);
    assign age_sum = {1'b0, rdata_reg.stamp} + {1'b0, max_age};
    assign old_hit = age_sum < {1'b0, item_reg.stamp};

    always_comb begin
        sts.rejected = (item_reg.ttl == '0) || (item_reg.chunks == '0);
        // Scan bound: occupancy for every operation; an eviction runs on a full table, so it covers all entries.
        sts.scan_end = (idx_reg >= occ_reg);
        sts.hit      = (op_reg == kto_pkg::OP_PRUNE) ? old_hit : key_eq;
        sts.full     = full;
    end

    // The write slot: the match for an update, the oldest entry for an
    // eviction, otherwise the append position.
    always_comb begin
        if (upd_reg) begin
            wr_addr = idx_reg[IDX_W-1:0];
        end else if (full) begin
            wr_addr = oldest_reg;
        end else begin
            wr_addr = occ_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd || cmd.rd_last) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr_item) begin
            mem[wr_addr] <= item_reg;
        end else if (cmd.move_last) begin
            mem[idx_reg[IDX_W-1:0]] <= rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            idx_reg     <= '0;
            removed_reg <= '0;
            upd_reg     <= 1'b0;
            evict_reg   <= 1'b0;
            op_reg      <= '0;
        end else begin
            if (cmd.load) begin
                item_reg    <= item_in;
                op_reg      <= op_in;
                idx_reg     <= '0;
                removed_reg <= '0;
                upd_reg     <= 1'b0;
                evict_reg   <= 1'b0;
            end else if (cmd.eval) begin
                if (op_reg == kto_pkg::OP_PRUNE) begin
                    if (!old_hit) begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end else if (key_eq) begin
                    upd_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                // Oldest tracking, strictly smaller keeps the lowest index.
                if (idx_reg == '0 || rdata_reg.stamp < oldest_time_reg) begin
                    oldest_reg      <= idx_reg[IDX_W-1:0];
                    oldest_time_reg <= rdata_reg.stamp;
                end
            end
            if (cmd.wr_item && !upd_reg && !full) begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
            // The eviction is noted at the write, before an append can fill
            // the table.
            if (cmd.wr_item && !upd_reg && full) begin
                evict_reg <= 1'b1;
            end
            if (cmd.rd_last) begin
                occ_reg     <= last_idx;
                removed_reg <= removed_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_out) begin
            found_out  <= '0;
            tally_out  <= '0;
            case (op_reg)
                kto_pkg::OP_ADD: begin
                    if (sts.rejected) begin
                        status_out <= kto_pkg::ST_REJECTED;
                    end else if (upd_reg) begin
                        status_out <= kto_pkg::ST_UPDATED;
                    end else if (evict_reg) begin
                        status_out <= kto_pkg::ST_EVICTED;
                    end else begin
                        status_out <= kto_pkg::ST_ADDED;
                    end
                end
                kto_pkg::OP_FIND: begin
                    if (upd_reg) begin
                        status_out <= kto_pkg::ST_FOUND;
                        found_out  <= rdata_reg;
                    end else begin
                        status_out <= kto_pkg::ST_NOTFOUND;
                    end
                end
                kto_pkg::OP_PRUNE: begin
                    status_out <= kto_pkg::ST_PRUNED;
                    tally_out  <= kto_pkg::TALLY_W'(removed_reg);
                end
                default: begin
                    status_out <= kto_pkg::ST_COUNT;
                    tally_out  <= kto_pkg::TALLY_W'(occ_reg);
                end
            endcase
        end
    end

endmodule

[rtl/kto_ctrl.sv]
// ============================================================================
// kto_ctrl: sequencing state machine for the keyed table
// Steps the datapath through the scan of each add, find or prune and the
// result handshake.
// ============================================================================
module kto_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_op,
    output logic          m_valid,
    input  logic          m_ready,
    output kto_pkg::cmd_t cmd,
    input  kto_pkg::sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_EVAL  = 8'b0000_1000,
        S_MOVE  = 8'b0001_0000,
        S_WRITE = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [1:0] op_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (op_reg == kto_pkg::OP_COUNT ||
                    (op_reg == kto_pkg::OP_ADD && sts.rejected)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (sts.scan_end) begin
                    state_next = (op_reg == kto_pkg::OP_ADD) ? S_WRITE : S_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.hit) begin
                    if (op_reg == kto_pkg::OP_PRUNE) begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_MOVE;
                    end else if (op_reg == kto_pkg::OP_ADD) begin
                        state_next = S_WRITE;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_READ;
                end
            end
            S_MOVE: begin
                cmd.move_last = 1'b1;
                state_next    = S_READ;
            end
            S_WRITE: begin
                cmd.wr_item = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.set_out    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load) begin
                op_reg <= s_op;
            end
        end
    end

endmodule

[rtl/keyed_table_oldest_eviction_unit.sv]
// ============================================================================
// keyed_table_oldest_eviction_unit: associative table with oldest eviction
// Top level: APB register, controller and datapath.
// ============================================================================
// The unit holds up to TABLE_ENTRIES entries keyed by a 256-bit hash in a
// single-port entry memory and runs one item at a time. Every add, find or
// prune walks the occupied entries, each with one memory read, then the
// compare on the registered data; a prune removal adds a step that moves
// the last entry into the hole. An add of a new key to a full table walks
// all entries to find the oldest. Count and rejected adds skip the scan.
// A finished result waits in the output register while the unit takes
// the next item. The prune_max_age register sits at byte address 0 and is
// 40 bits wide on a 64-bit APB data bus; write it only while the unit is
// idle.
module keyed_table_oldest_eviction_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [0:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [63:0]                   s_key_word0,
    input  logic [63:0]                   s_key_word1,
    input  logic [63:0]                   s_key_word2,
    input  logic [63:0]                   s_key_word3,
    input  logic [7:0]                    s_entry_ttl,
    input  logic [31:0]                   s_entry_chunks,
    input  logic [63:0]                   s_entry_tag,
    input  logic [39:0]                   s_now_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_found_ttl,
    output logic [31:0]                   m_found_chunks,
    output logic [63:0]                   m_found_tag,
    output logic [39:0]                   m_found_time,
    output logic [10:0]                   m_tally
);

    localparam logic [kto_pkg::TIME_W-1:0] MAX_AGE_RESET = 40'd3600;

    logic [kto_pkg::TIME_W-1:0] max_age_reg;
    kto_pkg::cmd_t              cmd;
    kto_pkg::sts_t              sts;
    kto_pkg::entry_t            item;
    kto_pkg::entry_t            found;

    // The only register lives at address zero; other addresses ignore writes.
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {24'd0, max_age_reg} : 64'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg <= MAX_AGE_RESET;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            max_age_reg <= pwdata[kto_pkg::TIME_W-1:0];
        end
    end

    assign item = '{key3: s_key_word3, key2: s_key_word2, key1: s_key_word1,
                    key0: s_key_word0, ttl: s_entry_ttl, chunks: s_entry_chunks,
                    tag: s_entry_tag, stamp: s_now_time};

    kto_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_operation),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    kto_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .item_in    (item),
        .op_in      (s_operation),
        .max_age    (max_age_reg),
        .status_out (m_status),
        .found_out  (found),
        .tally_out  (m_tally)
    );

    assign m_found_ttl    = found.ttl;
    assign m_found_chunks = found.chunks;
    assign m_found_tag    = found.tag;
    assign m_found_time   = found.stamp;

endmodule

[rtl/kto_checker.sv]
// ============================================================================
// kto_checker: port-level checks for the keyed table
// Watches the handshakes and result fields of the top level.
// ============================================================================
module kto_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_found_ttl,
    input logic [10:0] m_tally
);

    // A result stays offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped before it was taken");

    // An accepted item keeps the input closed in the following cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("unit took a second item without working the first");

    // Only a successful find carries entry fields.
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != kto_pkg::ST_FOUND |-> m_found_ttl == 8'd0)
        else $error("entry fields set on a non-find result");

    // Tally is zero except on prune and count.
    a_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != kto_pkg::ST_PRUNED && m_status != kto_pkg::ST_COUNT
        |-> m_tally == 11'd0)
        else $error("tally set on a result that carries none");

endmodule

bind keyed_table_oldest_eviction_unit kto_checker u_kto_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_found_ttl (m_found_ttl),
    .m_tally     (m_tally)
);
